/* rtl/wsdf_pkg.sv */
// Shared widths, codes and reset values for the WebSocket frame deframer.
package wsdf_pkg;

  localparam int BYTE_W      = 8;
  localparam int OUT_LEN_W   = 25;
  localparam int OPC_W       = 4;
  localparam int KIND_W      = 2;
  localparam int PHASE_W     = 3;
  localparam int STEP_W      = 3;
  localparam int KEY_W       = 32;
  localparam int LEN_CODE_W  = 7;
  // data_out, fin_flag, frame_opcode and frame_length, padded to whole bytes.
  localparam int M_TDATA_W   = 40;

  localparam int LEN_WIDTH_DEF = 25;

  localparam logic [OUT_LEN_W-1:0] MAX_LEN_RESET = OUT_LEN_W'(16 * 1024 * 1024);

  // Parser phases.
  localparam logic [PHASE_W-1:0] PH_BYTE0   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_BYTE1   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_EXTLEN  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_KEY     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
  localparam logic [PHASE_W-1:0] PH_ERROR   = 3'd5;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

  // Seven-bit length code that announces a 16-bit extended length.
  localparam logic [LEN_CODE_W-1:0] LEN_CODE_16 = 7'd126;

  // Extension and key byte counts, minus one.
  localparam logic [STEP_W-1:0] STEPS_EXT16 = 3'd1;
  localparam logic [STEP_W-1:0] STEPS_EXT64 = 3'd7;
  localparam logic [STEP_W-1:0] STEPS_KEY   = 3'd3;

endpackage

/* rtl/websocket_frame_deframer.sv */
// WebSocket receive-side frame parser: header, extended length, mask key, payload unmasking.
//
// Takes one received byte per cycle unless the output stalls, and returns at most one result
// per byte, in the cycle after the byte is accepted, from an output register. The header
// fields, length accumulator, mask key and payload counter are updated by a single step of
// logic per byte, so a new byte can be taken in every cycle as long as the output register
// is empty or being drained in the same cycle. Results on m_axis: tuser carries the kind
// (0 header, 1 payload byte, 2 length error); tlast marks the header of an empty frame,
// the final payload byte of a frame, and an error. After an error the parser swallows
// all further bytes until reset. The length cap is written through the cfg channel,
// which is always ready; write it only while the parser is idle.
module websocket_frame_deframer #(
  parameter int LEN_WIDTH = wsdf_pkg::LEN_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // cfg_data: max_payload_len [24:0]
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wsdf_pkg::OUT_LEN_W-1:0]      cfg_data,
  // s_axis_tdata: rx_byte [7:0]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [wsdf_pkg::BYTE_W-1:0]         s_axis_tdata,
  // m_axis_tdata: data_out [7:0], fin_flag [8], frame_opcode [12:9],
  // frame_length [37:13], zero [39:38]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [wsdf_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // m_axis_tuser: kind [1:0]
  output logic [wsdf_pkg::KIND_W-1:0]         m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int CMP_W = (LEN_WIDTH > wsdf_pkg::OUT_LEN_W) ? LEN_WIDTH : wsdf_pkg::OUT_LEN_W;
  localparam int PAD_W = wsdf_pkg::M_TDATA_W - wsdf_pkg::BYTE_W - 1 - wsdf_pkg::OPC_W
                         - wsdf_pkg::OUT_LEN_W;

  // Configuration and parser state.
  logic [wsdf_pkg::OUT_LEN_W-1:0] max_payload_len;
  logic [wsdf_pkg::PHASE_W-1:0]   phase, phase_next;
  logic [wsdf_pkg::STEP_W-1:0]    step_count, step_count_next;
  logic                           fin_reg, fin_reg_next;
  logic [wsdf_pkg::OPC_W-1:0]     opcode_reg, opcode_reg_next;
  logic                           masked_reg, masked_reg_next;
  logic [LEN_WIDTH-1:0]           length_accum, length_accum_next;
  logic                           length_overflow, length_overflow_next;
  logic [wsdf_pkg::KEY_W-1:0]     mask_key, mask_key_next;
  logic [LEN_WIDTH-1:0]           payload_index, payload_index_next;

  // Output register.
  logic                           out_valid;
  logic [wsdf_pkg::KIND_W-1:0]    out_kind;
  logic [wsdf_pkg::BYTE_W-1:0]    out_data;
  logic                           out_fin;
  logic [wsdf_pkg::OPC_W-1:0]     out_opcode;
  logic [wsdf_pkg::OUT_LEN_W-1:0] out_length;
  logic                           out_last;

  // Result of the current step.
  logic                           emit;
  logic [wsdf_pkg::KIND_W-1:0]    res_kind;
  logic [wsdf_pkg::BYTE_W-1:0]    res_data;
  logic [wsdf_pkg::OUT_LEN_W-1:0] res_length;
  logic                           res_last;

  logic                           in_accept;
  logic [wsdf_pkg::BYTE_W-1:0]    b;
  logic [wsdf_pkg::BYTE_W-1:0]    key_byte;
  logic [LEN_WIDTH:0]             index_plus_one;
  logic [CMP_W-1:0]               accum_wide;
  logic [CMP_W-1:0]               cap_wide;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;

  assign cap_wide       = CMP_W'(max_payload_len);
  assign index_plus_one = {1'b0, payload_index} + (LEN_WIDTH + 1)'(1);

  always_comb begin
    case (payload_index[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    logic do_length;
    logic do_header;
    logic is_last;
    phase_next           = phase;
    step_count_next      = step_count;
    fin_reg_next         = fin_reg;
    opcode_reg_next      = opcode_reg;
    masked_reg_next      = masked_reg;
    length_accum_next    = length_accum;
    length_overflow_next = length_overflow;
    mask_key_next        = mask_key;
    payload_index_next   = payload_index;
    emit                 = 1'b0;
    res_kind             = wsdf_pkg::KIND_HEADER;
    res_data             = '0;
    res_length           = '0;
    res_last             = 1'b0;
    do_length            = 1'b0;
    do_header            = 1'b0;
    is_last              = 1'b0;

    unique case (phase)
      wsdf_pkg::PH_BYTE0: begin
        fin_reg_next    = b[7];
        opcode_reg_next = b[wsdf_pkg::OPC_W-1:0];
        phase_next      = wsdf_pkg::PH_BYTE1;
      end
      wsdf_pkg::PH_BYTE1: begin
        masked_reg_next      = b[7];
        length_overflow_next = 1'b0;
        if (b[wsdf_pkg::LEN_CODE_W-1:0] < wsdf_pkg::LEN_CODE_16) begin
          length_accum_next = LEN_WIDTH'(b[wsdf_pkg::LEN_CODE_W-1:0]);
          do_length         = 1'b1;
        end else begin
          length_accum_next = '0;
          step_count_next   = (b[wsdf_pkg::LEN_CODE_W-1:0] == wsdf_pkg::LEN_CODE_16) ?
                              wsdf_pkg::STEPS_EXT16 : wsdf_pkg::STEPS_EXT64;
          phase_next        = wsdf_pkg::PH_EXTLEN;
        end
      end
      wsdf_pkg::PH_EXTLEN: begin
        // A nonzero top byte would be shifted out: the length does not fit.
        if (length_accum[LEN_WIDTH-1 -: wsdf_pkg::BYTE_W] != '0) begin
          length_overflow_next = 1'b1;
        end
        length_accum_next = (length_accum << wsdf_pkg::BYTE_W) | LEN_WIDTH'(b);
        if (step_count == '0) begin
          do_length = 1'b1;
        end else begin
          step_count_next = step_count - 1'b1;
        end
      end
      wsdf_pkg::PH_KEY: begin
        mask_key_next = {mask_key[wsdf_pkg::KEY_W-wsdf_pkg::BYTE_W-1:0], b};
        if (step_count == '0) begin
          do_header = 1'b1;
        end else begin
          step_count_next = step_count - 1'b1;
        end
      end
      wsdf_pkg::PH_PAYLOAD: begin
        is_last            = index_plus_one >= {1'b0, length_accum};
        emit               = 1'b1;
        res_kind           = wsdf_pkg::KIND_PAYLOAD;
        res_data           = masked_reg ? (b ^ key_byte) : b;
        res_length         = accum_wide[wsdf_pkg::OUT_LEN_W-1:0];
        res_last           = is_last;
        payload_index_next = index_plus_one[LEN_WIDTH-1:0];
        if (is_last) begin
          phase_next = wsdf_pkg::PH_BYTE0;
        end
      end
      wsdf_pkg::PH_ERROR: begin
      end
      default: begin
        phase_next = wsdf_pkg::PH_BYTE0;
      end
    endcase

    // The length is complete: check it, then take the key or finish the header.
    if (do_length) begin
      if (length_overflow_next || (CMP_W'(length_accum_next) > cap_wide)) begin
        phase_next = wsdf_pkg::PH_ERROR;
        emit       = 1'b1;
        res_kind   = wsdf_pkg::KIND_ERROR;
        res_last   = 1'b1;
      end else if (masked_reg_next) begin
        phase_next      = wsdf_pkg::PH_KEY;
        step_count_next = wsdf_pkg::STEPS_KEY;
        mask_key_next   = '0;
      end else begin
        do_header = 1'b1;
      end
    end

    if (do_header) begin
      emit               = 1'b1;
      res_kind           = wsdf_pkg::KIND_HEADER;
      res_length         = accum_wide[wsdf_pkg::OUT_LEN_W-1:0];
      res_last           = (length_accum_next == '0);
      payload_index_next = '0;
      phase_next         = (length_accum_next == '0) ? wsdf_pkg::PH_BYTE0 :
                           wsdf_pkg::PH_PAYLOAD;
    end
  end

  assign accum_wide = CMP_W'(length_accum_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= wsdf_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= wsdf_pkg::PH_BYTE0;
      step_count      <= '0;
      fin_reg         <= 1'b0;
      opcode_reg      <= '0;
      masked_reg      <= 1'b0;
      length_accum    <= '0;
      length_overflow <= 1'b0;
      mask_key        <= '0;
      payload_index   <= '0;
    end else if (in_accept) begin
      phase           <= phase_next;
      step_count      <= step_count_next;
      fin_reg         <= fin_reg_next;
      opcode_reg      <= opcode_reg_next;
      masked_reg      <= masked_reg_next;
      length_accum    <= length_accum_next;
      length_overflow <= length_overflow_next;
      mask_key        <= mask_key_next;
      payload_index   <= payload_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_kind   <= res_kind;
      out_data   <= res_data;
      out_fin    <= fin_reg_next;
      out_opcode <= opcode_reg_next;
      out_length <= res_length;
      out_last   <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_length, out_opcode, out_fin, out_data};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

  // The error phase is terminal until reset.
  assert property (@(posedge clk) disable iff (rst)
    phase == wsdf_pkg::PH_ERROR |=> phase == wsdf_pkg::PH_ERROR)
    else $error("parser left the error phase without reset");

  // An error result always closes the frame and carries no length.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == wsdf_pkg::KIND_ERROR |-> out_last && out_length == '0)
    else $error("error result without last or with a nonzero length");

  // While payload is flowing the byte counter stays below the frame length.
  assert property (@(posedge clk) disable iff (rst)
    phase == wsdf_pkg::PH_PAYLOAD |-> payload_index < length_accum)
    else $error("payload counter ran past the frame length");

  // The key is four bytes long.
  assert property (@(posedge clk) disable iff (rst)
    phase == wsdf_pkg::PH_KEY |-> step_count <= wsdf_pkg::STEPS_KEY)
    else $error("mask key byte count out of range");

  // No byte is taken while a result waits and the sink is stalled.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while the output register is blocked");

endmodule

/* bench/websocket_frame_deframer_test.sv */
// Self-checking testbench for the WebSocket frame deframer with its own frame predictor.
module websocket_frame_deframer_test;

  localparam logic [wsdf_pkg::LEN_CODE_W-1:0] LEN_CODE_64 = 7'd127;

  typedef struct packed {
    logic [wsdf_pkg::KIND_W-1:0]    kind;
    logic [wsdf_pkg::BYTE_W-1:0]    data;
    logic                           fin;
    logic [wsdf_pkg::OPC_W-1:0]     opc;
    logic [wsdf_pkg::OUT_LEN_W-1:0] len;
    logic                           last;
  } frame_res_t;

  typedef struct packed {
    logic [wsdf_pkg::BYTE_W-1:0] b;
    logic                        typed;
    frame_res_t                  want;
  } stim_row_t;

  localparam frame_res_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [wsdf_pkg::OUT_LEN_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [wsdf_pkg::BYTE_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [wsdf_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic [wsdf_pkg::KIND_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  websocket_frame_deframer uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Parser state as the frame predictor sees it.
  logic [wsdf_pkg::PHASE_W-1:0]   ph = wsdf_pkg::PH_BYTE0;
  logic [wsdf_pkg::STEP_W-1:0]    steps = '0;
  logic                           fin_q = 1'b0;
  logic [wsdf_pkg::OPC_W-1:0]     opc_q = '0;
  logic                           msk_q = 1'b0;
  logic [wsdf_pkg::OUT_LEN_W-1:0] len_acc = '0;
  logic                           len_ovf = 1'b0;
  logic [wsdf_pkg::KEY_W-1:0]     key = '0;
  logic [wsdf_pkg::OUT_LEN_W-1:0] pidx = '0;
  logic [wsdf_pkg::OUT_LEN_W-1:0] cap = wsdf_pkg::MAX_LEN_RESET;

  frame_res_t expected_q [$];
  frame_res_t seen;
  frame_res_t want;
  int send_idle_pct = 9;
  int recv_idle_pct = 62;
  int hold_left = 0;
  int bytes_sent = 0;
  int fail_cnt = 0;
  int hdr_cnt = 0;
  int pay_cnt = 0;
  int err_cnt = 0;

  // Typed-in empty-frame header, one-byte frame, masked frame wrapping the key, 64-bit empty frame.
  stim_row_t dir_rows [26] = '{
    '{8'h8F, 1'b0, NO_RES},
    '{8'h00, 1'b1, '{wsdf_pkg::KIND_HEADER, 8'h00, 1'b1, 4'hF, 25'd0, 1'b1}},
    '{8'h00, 1'b0, NO_RES},
    '{8'h01, 1'b1, '{wsdf_pkg::KIND_HEADER, 8'h00, 1'b0, 4'h0, 25'd1, 1'b0}},
    '{8'hFF, 1'b1, '{wsdf_pkg::KIND_PAYLOAD, 8'hFF, 1'b0, 4'h0, 25'd1, 1'b1}},
    '{8'h72, 1'b0, NO_RES},
    '{8'h85, 1'b0, NO_RES},
    '{8'hA5, 1'b0, NO_RES},
    '{8'h5A, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h01, 1'b1, '{wsdf_pkg::KIND_HEADER, 8'h00, 1'b0, 4'h2, 25'd5, 1'b0}},
    '{8'h00, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h0F, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{8'h55, 1'b0, NO_RES},
    '{8'h8A, 1'b0, NO_RES},
    '{8'h7F, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b1, '{wsdf_pkg::KIND_HEADER, 8'h00, 1'b1, 4'hA, 25'd0, 1'b1}}
  };

  function automatic bit header_done(output frame_res_t r);
    r = '{kind: wsdf_pkg::KIND_HEADER, data: 8'h00, fin: fin_q, opc: opc_q, len: len_acc,
          last: (len_acc == 0)};
    pidx = '0;
    ph = (len_acc == 0) ? wsdf_pkg::PH_BYTE0 : wsdf_pkg::PH_PAYLOAD;
    return 1'b1;
  endfunction

  // The length is checked before any mask key byte is taken.
  function automatic bit length_done(output frame_res_t r);
    r = NO_RES;
    if (len_ovf || len_acc > cap) begin
      ph = wsdf_pkg::PH_ERROR;
      r = '{kind: wsdf_pkg::KIND_ERROR, data: 8'h00, fin: fin_q, opc: opc_q, len: '0,
            last: 1'b1};
      return 1'b1;
    end
    if (msk_q) begin
      ph = wsdf_pkg::PH_KEY;
      steps = wsdf_pkg::STEPS_KEY;
      key = '0;
      return 1'b0;
    end
    return header_done(r);
  endfunction

  function automatic bit parse_byte(input logic [wsdf_pkg::BYTE_W-1:0] b,
                                    output frame_res_t r);
    logic [wsdf_pkg::LEN_CODE_W-1:0] code;
    logic [wsdf_pkg::BYTE_W-1:0] data;
    logic last;
    r = NO_RES;
    case (ph)
      wsdf_pkg::PH_BYTE0: begin
        fin_q = b[7];
        opc_q = b[3:0];
        ph = wsdf_pkg::PH_BYTE1;
        return 1'b0;
      end
      wsdf_pkg::PH_BYTE1: begin
        code = b[6:0];
        msk_q = b[7];
        len_acc = '0;
        len_ovf = 1'b0;
        if (code < wsdf_pkg::LEN_CODE_16) begin
          len_acc = wsdf_pkg::OUT_LEN_W'(code);
          return length_done(r);
        end
        steps = (code == wsdf_pkg::LEN_CODE_16) ? wsdf_pkg::STEPS_EXT16 :
                wsdf_pkg::STEPS_EXT64;
        ph = wsdf_pkg::PH_EXTLEN;
        return 1'b0;
      end
      wsdf_pkg::PH_EXTLEN: begin
        // Any bit shifted out of the accumulator makes the length too long.
        if (len_acc[wsdf_pkg::OUT_LEN_W-1:wsdf_pkg::OUT_LEN_W-8] != 0) len_ovf = 1'b1;
        len_acc = {len_acc[wsdf_pkg::OUT_LEN_W-9:0], b};
        if (steps == 0) return length_done(r);
        steps = steps - 1'b1;
        return 1'b0;
      end
      wsdf_pkg::PH_KEY: begin
        key = {key[wsdf_pkg::KEY_W-9:0], b};
        if (steps == 0) return header_done(r);
        steps = steps - 1'b1;
        return 1'b0;
      end
      wsdf_pkg::PH_PAYLOAD: begin
        data = msk_q ? (b ^ key[8*(3 - pidx[1:0]) +: 8]) : b;
        last = ({1'b0, pidx} + 26'd1 >= {1'b0, len_acc});
        r = '{kind: wsdf_pkg::KIND_PAYLOAD, data: data, fin: fin_q, opc: opc_q, len: len_acc,
              last: last};
        pidx = pidx + 1'b1;
        if (last) ph = wsdf_pkg::PH_BYTE0;
        return 1'b1;
      end
      wsdf_pkg::PH_ERROR: return 1'b0;
      default: begin
        ph = wsdf_pkg::PH_BYTE0;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic string show(input frame_res_t r);
    return $sformatf("kind=%0d data=%02h fin=%0d opc=%0d len=%0d last=%0d",
                     r.kind, r.data, r.fin, r.opc, r.len, r.last);
  endfunction

  task automatic send_byte(input logic [wsdf_pkg::BYTE_W-1:0] b, input logic typed,
                           input frame_res_t typed_res);
    frame_res_t r;
    bit got;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    got = parse_byte(b, r);
    if (typed) expected_q.push_back(typed_res);
    else if (got) expected_q.push_back(r);
    bytes_sent++;
  endtask

  task automatic put_byte(input logic [wsdf_pkg::BYTE_W-1:0] b);
    send_byte(b, 1'b0, NO_RES);
  endtask

  // Waits until every result is back, then lets the parser settle.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cap(input logic [wsdf_pkg::OUT_LEN_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cap = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [wsdf_pkg::OUT_LEN_W-1:0] len, input logic masked);
    logic [wsdf_pkg::KEY_W-1:0] frame_key;
    logic [63:0] ext;
    int code_sel;
    ext = 64'(len);
    frame_key = $urandom;
    if (len < 126 && $urandom_range(3) != 0) code_sel = 0;
    else if (len < 65536 && $urandom_range(1) == 1) code_sel = 1;
    else code_sel = 2;
    put_byte(8'($urandom_range(255)));
    case (code_sel)
      0: put_byte({masked, len[6:0]});
      1: begin
        put_byte({masked, wsdf_pkg::LEN_CODE_16});
        put_byte(len[15:8]);
        put_byte(len[7:0]);
      end
      default: begin
        put_byte({masked, LEN_CODE_64});
        for (int i = 7; i >= 0; i--) put_byte(ext[8*i +: 8]);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) put_byte(frame_key[8*i +: 8]);
    for (int i = 0; i < len; i++) put_byte(8'($urandom_range(255)));
  endtask

  // Well-formed frames within the current cap, mostly short ones.
  task automatic run_frames(input int budget);
    int start;
    int lim;
    logic [wsdf_pkg::OUT_LEN_W-1:0] len;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      lim = (cap > 12) ? 12 : int'(cap);
      case ($urandom_range(15))
        0: len = (cap >= 126) ?
                 wsdf_pkg::OUT_LEN_W'($urandom_range(cap > 300 ? 300 : cap, 126)) :
                 wsdf_pkg::OUT_LEN_W'(lim);
        1: len = (cap > 40) ? wsdf_pkg::OUT_LEN_W'(40) : cap;
        default: len = wsdf_pkg::OUT_LEN_W'($urandom_range(lim));
      endcase
      send_frame(len, 1'($urandom_range(1)));
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen = '{kind: m_axis_tuser, data: m_axis_tdata[7:0], fin: m_axis_tdata[8],
               opc: m_axis_tdata[12:9], len: m_axis_tdata[37:13], last: m_axis_tlast};
      case (seen.kind)
        wsdf_pkg::KIND_HEADER: hdr_cnt++;
        wsdf_pkg::KIND_PAYLOAD: pay_cnt++;
        default: err_cnt++;
      endcase
      if (expected_q.size() == 0) begin
        if (fail_cnt < 10) $display("unexpected result: %s", show(seen));
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (seen !== want) begin
          if (fail_cnt < 10) begin
            $display("mismatch: expected %s", show(want));
            $display("          actual   %s", show(seen));
          end
          fail_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [wsdf_pkg::OUT_LEN_W-1:0] phase_caps [6];
    logic [wsdf_pkg::OUT_LEN_W-1:0] capv;
    logic [15:0] len16;
    logic m;
    phase_caps[0] = '0;
    phase_caps[1] = '1;
    phase_caps[2] = wsdf_pkg::MAX_LEN_RESET;
    phase_caps[3] = wsdf_pkg::OUT_LEN_W'($urandom_range(40, 1));
    phase_caps[4] = wsdf_pkg::OUT_LEN_W'(125);
    phase_caps[5] = wsdf_pkg::OUT_LEN_W'($urandom_range(5000, 41));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 9 : (p < 4) ? 62 : 0;
      recv_idle_pct = (p < 2) ? 62 : (p < 4) ? 9 : 0;
      set_cap(phase_caps[p]);
      if (p == 2) begin
        // The receiver stalls while a long masked frame keeps coming.
        hold_left = 60;
        send_frame(wsdf_pkg::OUT_LEN_W'(40), 1'b1);
      end
      run_frames(60);
    end

    // The error is sticky, so a single bad length closes the run.
    m = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: begin
        capv = wsdf_pkg::OUT_LEN_W'($urandom_range(100));
        set_cap(capv);
        put_byte(8'($urandom_range(255)));
        put_byte({m, 7'(capv + 1)});
      end
      1: begin
        capv = wsdf_pkg::OUT_LEN_W'($urandom_range(1000, 200));
        set_cap(capv);
        len16 = 16'($urandom_range(65535, capv + 1));
        put_byte(8'($urandom_range(255)));
        put_byte({m, wsdf_pkg::LEN_CODE_16});
        put_byte(len16[15:8]);
        put_byte(len16[7:0]);
      end
      2: begin
        set_cap('1);
        put_byte(8'($urandom_range(255)));
        put_byte({m, LEN_CODE_64});
        put_byte(8'h80 | 8'($urandom_range(255)));
        repeat (7) put_byte(8'($urandom_range(255)));
      end
      default: begin
        set_cap('1);
        put_byte(8'($urandom_range(255)));
        put_byte({m, LEN_CODE_64});
        repeat (4) put_byte(8'h00);
        put_byte(8'h02);
        repeat (3) put_byte(8'($urandom_range(255)));
      end
    endcase
    repeat (12) put_byte(8'($urandom_range(255)));

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Run covered %0d input bytes over six length caps and a closing bad length.",
             bytes_sent);
    $display("Results seen: %0d headers, %0d payload bytes, %0d length errors, %0d mismatches.",
             hdr_cnt, pay_cnt, err_cnt, fail_cnt);
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 300000);
    $display("FAIL");
    $finish;
  end

endmodule
